/* rtl/core/ids_pkg.sv */
// ----------------------------------------------------------------------------
// ids_pkg - shared types and constants of the indexed deque store
// Operation codes, status codes, cell modes and the fixed field widths of
// the request and response beats.
// ----------------------------------------------------------------------------
package ids_pkg;

    // Default sizes of the store
    localparam int DEPTH_DEF    = 64;
    localparam int ID_WIDTH_DEF = 16;

    // Fixed field widths of the stream beats
    localparam int OP_W    = 3;
    localparam int POS_W   = 8;
    localparam int ITEM_W  = 16;
    localparam int STAT_W  = 2;
    localparam int FOUND_W = 7;
    localparam int OCC_W   = 7;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // Request operations
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_REMOVE     = 3'd5,
        OP_READ       = 3'd6,
        OP_FIND       = 3'd7
    } t_op;

    // Response status
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // Position reported when nothing was found
    localparam logic [FOUND_W-1:0] NONE_POS = 7'h7F;

    // Per-cycle action broadcast to the cell chain
    typedef enum logic [1:0] {
        MD_HOLD  = 2'd0,
        MD_OPEN  = 2'd1,   // cells above the index take the left neighbor
        MD_CLOSE = 2'd2    // cells at and above the index take the right neighbor
    } t_mode;

endpackage

/* rtl/core/ids_cell.sv */
// ----------------------------------------------------------------------------
// ids_cell - one entry of the deque cell chain
// Holds one identifier, shifts toward the back to open a gap or toward the
// front to close one, and compares its entry against the search key.
// ----------------------------------------------------------------------------
module ids_cell #(
    parameter int ID_WIDTH = ids_pkg::ID_WIDTH_DEF,
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  ids_pkg::t_mode       i_mode,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic [ID_WIDTH-1:0]  i_id,
    input  logic [CNT_W-1:0]     i_cnt,
    input  logic [ID_WIDTH-1:0]  i_left,
    input  logic [ID_WIDTH-1:0]  i_right,
    output logic [ID_WIDTH-1:0]  o_val,
    output logic                 o_match
);

    logic [ID_WIDTH-1:0] r_val;
    logic                w_above;
    logic                w_at;

    assign w_above = IDX_W'(CELL_IDX) > i_idx;
    assign w_at    = IDX_W'(CELL_IDX) == i_idx;

    // Load, shift or hold the entry
    always_ff @(posedge i_clk) begin
        case (i_mode)
            ids_pkg::MD_OPEN: begin
                if (w_above) begin
                    r_val <= i_left;
                end else if (w_at) begin
                    r_val <= i_id;
                end
            end
            ids_pkg::MD_CLOSE: begin
                if (w_above || w_at) begin
                    r_val <= i_right;
                end
            end
            default: begin
                r_val <= r_val;
            end
        endcase
    end

    assign o_val   = r_val;
    // Match only occupied entries
    assign o_match = (r_val == i_id) && (CNT_W'(CELL_IDX) < i_cnt);

endmodule

/* rtl/core/indexed_deque_store.sv */
// ----------------------------------------------------------------------------
// indexed_deque_store - ordered list of identifiers with deque and indexed access
// A chain of cells holds the list and resolves every request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: the operation in tuser, the signed
//   position and the identifier in tdata. Every request beat gives exactly one
//   response beat on m_axis with status, item, found position and occupancy.
//   The response is registered on the edge that accepts the request, and
//   throughput is one request per cycle while responses are taken;
//   every entry shifts in the same cycle through the cell chain, and
//   the read select and first-match search span all cells in that cycle.
//   When the receiver stalls, the response register holds and s_axis_tready
//   drops until the response is taken; the list does not change meanwhile.
//   Reset empties the list (occupancy zero) and clears the response valid;
//   the cell contents are not cleared and are never shown while unoccupied.
//   Errors (empty list, position out of range, not found, full) leave the
//   list unchanged and report a nonzero status with a zero item.
// ----------------------------------------------------------------------------
module indexed_deque_store #(
    parameter int DEPTH    = ids_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = ids_pkg::ID_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] position, [23:8] item_id
    input  logic [ids_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [2:0] op
    input  logic [ids_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] status, [17:2] item_out, [24:18] found_at, [31:25] occupancy
    output logic [ids_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PW    = ((CNT_W > ids_pkg::POS_W) ? CNT_W : ids_pkg::POS_W) + 2;

    // Request fields
    logic                             w_acc;
    ids_pkg::t_op                     w_op;
    logic signed [ids_pkg::POS_W-1:0] w_pos;
    logic [ids_pkg::ITEM_W-1:0]       w_item_in;
    logic [ID_WIDTH-1:0]              w_id;

    // List state
    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 n_count;
    logic [ID_WIDTH-1:0]              w_vals [DEPTH];
    logic [DEPTH-1:0]                 w_match;

    // Control to the chain
    ids_pkg::t_mode                   w_mode;
    ids_pkg::t_mode                   w_mode_q;
    logic [IDX_W-1:0]                 w_idx;

    // Position resolution
    logic signed [PW-1:0]             w_ps;
    logic signed [PW-1:0]             w_ns;
    logic                             w_full;
    logic                             w_empty;
    logic                             w_ins_ok;
    logic [IDX_W-1:0]                 w_ins_idx;
    logic                             w_ent_ok;
    logic [IDX_W-1:0]                 w_ent_idx;
    logic                             w_hit;
    logic [IDX_W-1:0]                 w_hit_idx;

    // Response
    logic                             w_take;
    logic [ID_WIDTH-1:0]              w_sel_val;
    logic [ids_pkg::ITEM_W-1:0]       w_item_out;
    logic [ids_pkg::STAT_W-1:0]       w_status;
    logic [ids_pkg::FOUND_W-1:0]      w_found;
    logic                             r_ovalid;
    logic [ids_pkg::STAT_W-1:0]       r_status;
    logic [ids_pkg::ITEM_W-1:0]       r_item;
    logic [ids_pkg::FOUND_W-1:0]      r_found;
    logic [ids_pkg::OCC_W-1:0]        r_occ;

    // Unpack the request beat
    assign w_acc     = s_axis_tvalid && s_axis_tready;
    assign w_op      = ids_pkg::t_op'(s_axis_tuser);
    assign w_pos     = signed'(s_axis_tdata[ids_pkg::POS_W-1:0]);
    assign w_item_in = s_axis_tdata[ids_pkg::POS_W +: ids_pkg::ITEM_W];

    // Fit the identifier to the stored width
    always_comb begin
        w_id = '0;
        for (int b = 0; b < ID_WIDTH; b++) begin
            if (b < ids_pkg::ITEM_W) begin
                w_id[b] = w_item_in[b];
            end
        end
    end

    // Resolve signed positions against the occupancy
    assign w_ps    = PW'(w_pos);
    assign w_ns    = signed'(PW'(r_count));
    assign w_full  = r_count == CNT_W'(DEPTH);
    assign w_empty = r_count == '0;

    always_comb begin
        w_ins_ok  = 1'b0;
        w_ins_idx = '0;
        if (w_ps >= 0 && w_ps <= w_ns) begin
            w_ins_ok  = 1'b1;
            w_ins_idx = w_ps[IDX_W-1:0];
        end else if (w_ps < 0 && w_ps >= -w_ns - PW'(1)) begin
            w_ins_ok  = 1'b1;
            w_ins_idx = IDX_W'(w_ns + PW'(1) + w_ps);
        end
    end

    always_comb begin
        w_ent_ok  = 1'b0;
        w_ent_idx = '0;
        if (w_ps >= 0 && w_ps < w_ns) begin
            w_ent_ok  = 1'b1;
            w_ent_idx = w_ps[IDX_W-1:0];
        end else if (w_ps < 0 && w_ps >= -w_ns) begin
            w_ent_ok  = 1'b1;
            w_ent_idx = IDX_W'(w_ns + w_ps);
        end
    end

    // Find the first occupied match
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit     = 1'b1;
                w_hit_idx = IDX_W'(i);
            end
        end
    end

    // Decode the operation into a chain action and a response
    always_comb begin
        w_mode   = ids_pkg::MD_HOLD;
        w_idx    = '0;
        n_count  = r_count;
        w_status = ids_pkg::ST_OK;
        w_take   = 1'b0;
        w_found  = ids_pkg::NONE_POS;
        unique case (w_op)
            ids_pkg::OP_PUSH_FRONT, ids_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ids_pkg::ST_FULL;
                end else begin
                    w_mode  = ids_pkg::MD_OPEN;
                    w_idx   = (w_op == ids_pkg::OP_PUSH_FRONT) ? '0 : r_count[IDX_W-1:0];
                    n_count = r_count + CNT_W'(1);
                end
            end
            ids_pkg::OP_POP_FRONT, ids_pkg::OP_POP_BACK: begin
                if (w_empty) begin
                    w_status = ids_pkg::ST_MISS;
                end else begin
                    w_mode  = ids_pkg::MD_CLOSE;
                    w_idx   = (w_op == ids_pkg::OP_POP_FRONT) ? '0 :
                              IDX_W'(r_count - CNT_W'(1));
                    w_take  = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            ids_pkg::OP_INSERT: begin
                if (w_full) begin
                    w_status = ids_pkg::ST_FULL;
                end else if (!w_ins_ok) begin
                    w_status = ids_pkg::ST_MISS;
                end else begin
                    w_mode  = ids_pkg::MD_OPEN;
                    w_idx   = w_ins_idx;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ids_pkg::OP_REMOVE, ids_pkg::OP_READ: begin
                w_idx = w_ent_idx;
                if (!w_ent_ok) begin
                    w_status = ids_pkg::ST_MISS;
                end else begin
                    w_take = 1'b1;
                    if (w_op == ids_pkg::OP_REMOVE) begin
                        w_mode  = ids_pkg::MD_CLOSE;
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            ids_pkg::OP_FIND: begin
                if (w_hit) begin
                    w_found = ids_pkg::FOUND_W'(w_hit_idx);
                end else begin
                    w_status = ids_pkg::ST_MISS;
                end
            end
            default: begin
                w_status = ids_pkg::ST_MISS;
            end
        endcase
    end

    // Act on the chain only for an accepted beat
    assign w_mode_q = w_acc ? w_mode : ids_pkg::MD_HOLD;

    // Cell chain: one entry per cell, front at cell zero
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ID_WIDTH-1:0] w_left;
        logic [ID_WIDTH-1:0] w_right;

        if (g == 0) begin : g_front
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_vals[g-1];
        end
        if (g == DEPTH - 1) begin : g_back
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_vals[g+1];
        end

        ids_cell #(
            .ID_WIDTH (ID_WIDTH),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_mode  (w_mode_q),
            .i_idx   (w_idx),
            .i_id    (w_id),
            .i_cnt   (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .o_val   (w_vals[g]),
            .o_match (w_match[g])
        );
    end

    // Select the entry leaving or read, fitted to the item field
    assign w_sel_val = w_vals[w_idx];
    always_comb begin
        w_item_out = '0;
        for (int b = 0; b < ids_pkg::ITEM_W; b++) begin
            if (b < ID_WIDTH) begin
                w_item_out[b] = w_take & w_sel_val[b];
            end
        end
    end

    // Occupancy and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count  <= n_count;
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Capture the response payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= w_status;
            r_item   <= w_item_out;
            r_found  <= w_found;
            r_occ    <= ids_pkg::OCC_W'(n_count);
        end
    end

    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_occ, r_found, r_item, r_status};

    // Occupancy never passes the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy above capacity");

    // A push into a list with room grows it by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_full &&
         (w_op == ids_pkg::OP_PUSH_FRONT || w_op == ids_pkg::OP_PUSH_BACK))
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("push did not grow the list");

    // An error response carries no item and leaves the list size alone
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_status != ids_pkg::ST_OK)
        |=> (r_item == '0) && (r_count == $past(r_count)))
        else $error("error response changed state or carried an item");

    // Every accepted request leaves a response pending
    a_resp_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_ovalid)
        else $error("accepted request produced no response");

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb - self-checking bench for indexed_deque_store
// Drives requests on the slave stream and compares every response beat with
// a behavioral copy of the list or a pinned value. Two short directed tables cover the empty,
// full and out-of-range cases. Random requests follow, mostly well-formed
// positions around the current fill level, under three idling mixes.
// ----------------------------------------------------------------------------
module tb;

    localparam int LIST_DEPTH = ids_pkg::DEPTH_DEF;
    localparam int RAND_PER_PHASE = 187;

    // Response fields from the top bit of m_axis_tdata down
    typedef struct packed {
        logic [ids_pkg::OCC_W-1:0]   occ;
        logic [ids_pkg::FOUND_W-1:0] found;
        logic [ids_pkg::ITEM_W-1:0]  item;
        logic [ids_pkg::STAT_W-1:0]  status;
    } t_resp;

    // A pinned response replaces the computed one for a directed row
    typedef struct {
        bit    pin;
        t_resp want;
    } t_pin_entry;

    typedef struct {
        ids_pkg::t_op op;
        logic [7:0]   pos;
        logic [15:0]  id;
        bit           pin;
        t_resp        want;
    } t_dir_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // [7:0] position, [23:8] item_id
    logic [ids_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [2:0] op
    logic [ids_pkg::OP_W-1:0]       s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [1:0] status, [17:2] item_out, [24:18] found_at, [31:25] occupancy
    logic [ids_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    logic [ids_pkg::ITEM_W-1:0] id_list_q[$];
    t_resp                      resp_expect_q[$];
    t_pin_entry                 pin_q[$];
    int                         mismatch_cnt = 0;
    int                         snd_idle_pct = 17;
    int                         rcv_idle_pct = 56;

    indexed_deque_store i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stall the response side at random
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Apply one request to the list copy and return the response it gives
    function automatic t_resp deque_apply(ids_pkg::t_op op, logic signed [7:0] pos,
                                          logic [ids_pkg::ITEM_W-1:0] id);
        t_resp r;
        int    n;
        int    p;
        int    idx;
        r.status = ids_pkg::ST_OK;
        r.item   = '0;
        r.found  = ids_pkg::NONE_POS;
        n   = id_list_q.size();
        p   = pos;
        idx = -1;
        case (op) inside
            ids_pkg::OP_PUSH_FRONT, ids_pkg::OP_PUSH_BACK: begin
                if (n >= LIST_DEPTH) begin
                    r.status = ids_pkg::ST_FULL;
                end else if (op == ids_pkg::OP_PUSH_FRONT) begin
                    id_list_q.insert(0, id);
                end else begin
                    id_list_q.insert(n, id);
                end
            end
            ids_pkg::OP_POP_FRONT, ids_pkg::OP_POP_BACK: begin
                if (n == 0) begin
                    r.status = ids_pkg::ST_MISS;
                end else if (op == ids_pkg::OP_POP_FRONT) begin
                    r.item = id_list_q[0];
                    id_list_q.delete(0);
                end else begin
                    r.item = id_list_q[n - 1];
                    id_list_q.delete(n - 1);
                end
            end
            ids_pkg::OP_INSERT: begin
                if (p >= 0 && p <= n) idx = p;
                else if (p < 0 && p >= -n - 1) idx = n + 1 + p;
                // fullness wins over a bad position
                if (n >= LIST_DEPTH) r.status = ids_pkg::ST_FULL;
                else if (idx < 0) r.status = ids_pkg::ST_MISS;
                else id_list_q.insert(idx, id);
            end
            ids_pkg::OP_REMOVE, ids_pkg::OP_READ: begin
                if (p >= 0 && p < n) idx = p;
                else if (p < 0 && p >= -n) idx = n + p;
                if (idx < 0) begin
                    r.status = ids_pkg::ST_MISS;
                end else begin
                    r.item = id_list_q[idx];
                    if (op == ids_pkg::OP_REMOVE) id_list_q.delete(idx);
                end
            end
            default: begin
                for (int i = 0; i < n && idx < 0; i++) begin
                    if (id_list_q[i] == id) idx = i;
                end
                if (idx < 0) r.status = ids_pkg::ST_MISS;
                else r.found = ids_pkg::FOUND_W'(idx);
            end
        endcase
        r.occ = ids_pkg::OCC_W'(id_list_q.size());
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // Check response beats and record accepted request beats
    t_resp      mon_want;
    t_resp      mon_calc;
    t_pin_entry mon_pin;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (resp_expect_q.size() == 0) begin
                    flag_mismatch("response with none pending", m_axis_tdata, 32'h0);
                end else begin
                    mon_want = resp_expect_q[0];
                    resp_expect_q.delete(0);
                    if (m_axis_tdata[1:0] !== mon_want.status)
                        flag_mismatch("status", m_axis_tdata[1:0], mon_want.status);
                    if (m_axis_tdata[17:2] !== mon_want.item)
                        flag_mismatch("item_out", m_axis_tdata[17:2], mon_want.item);
                    if (m_axis_tdata[24:18] !== mon_want.found)
                        flag_mismatch("found_at", m_axis_tdata[24:18], mon_want.found);
                    if (m_axis_tdata[31:25] !== mon_want.occ)
                        flag_mismatch("occupancy", m_axis_tdata[31:25], mon_want.occ);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                mon_pin = pin_q[0];
                pin_q.delete(0);
                mon_calc = deque_apply(ids_pkg::t_op'(s_axis_tuser), s_axis_tdata[7:0],
                                       s_axis_tdata[23:8]);
                resp_expect_q.insert(resp_expect_q.size(),
                                     mon_pin.pin ? mon_pin.want : mon_calc);
            end
        end
    end

    // Present one request beat and hold it until taken; entered at a falling edge
    task automatic send_req(input ids_pkg::t_op op, input logic [7:0] pos,
                            input logic [15:0] id, input bit pin, input t_resp want);
        t_pin_entry e;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        e.pin  = pin;
        e.want = want;
        pin_q.insert(pin_q.size(), e);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {id, pos};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic t_dir_row dr(ids_pkg::t_op op, logic [7:0] pos, logic [15:0] id,
                                    bit pin, logic [1:0] st, logic [15:0] item,
                                    logic [6:0] occ);
        t_dir_row row;
        row.op          = op;
        row.pos         = pos;
        row.id          = id;
        row.pin         = pin;
        row.want.status = st;
        row.want.item   = item;
        row.want.found  = ids_pkg::NONE_POS;
        row.want.occ    = occ;
        return row;
    endfunction

    initial begin : stim
        t_dir_row     opening_tbl[$];
        t_dir_row     full_tbl[$];
        ids_pkg::t_op op;
        logic [7:0]   pos;
        logic [15:0]  id;
        int           n;
        int           r;
        bit           growing;

        opening_tbl = {
            // Empty list, then build a short list through every entry path
            dr(ids_pkg::OP_POP_FRONT, 8'd0, 16'h0000, 1, ids_pkg::ST_MISS, 16'h0, 7'd0),
            dr(ids_pkg::OP_POP_BACK, 8'd0, 16'h0000, 1, ids_pkg::ST_MISS, 16'h0, 7'd0),
            dr(ids_pkg::OP_REMOVE, 8'd0, 16'h0000, 1, ids_pkg::ST_MISS, 16'h0, 7'd0),
            dr(ids_pkg::OP_READ, -8'sd1, 16'h0000, 1, ids_pkg::ST_MISS, 16'h0, 7'd0),
            dr(ids_pkg::OP_FIND, 8'd0, 16'h0000, 1, ids_pkg::ST_MISS, 16'h0, 7'd0),
            dr(ids_pkg::OP_INSERT, -8'sd1, 16'hFFFF, 1, ids_pkg::ST_OK, 16'h0, 7'd1),
            dr(ids_pkg::OP_READ, 8'd0, 16'h0000, 1, ids_pkg::ST_OK, 16'hFFFF, 7'd1),
            dr(ids_pkg::OP_PUSH_FRONT, 8'd0, 16'h0000, 1, ids_pkg::ST_OK, 16'h0, 7'd2),
            dr(ids_pkg::OP_PUSH_BACK, 8'hFF, 16'hA5A5, 1, ids_pkg::ST_OK, 16'h0, 7'd3),
            // append at position equal to size, then insert at the front from the back
            dr(ids_pkg::OP_INSERT, 8'd3, 16'h5A5A, 1, ids_pkg::ST_OK, 16'h0, 7'd4),
            dr(ids_pkg::OP_INSERT, -8'sd5, 16'h1234, 1, ids_pkg::ST_OK, 16'h0, 7'd5),
            dr(ids_pkg::OP_INSERT, 8'd6, 16'h7777, 1, ids_pkg::ST_MISS, 16'h0, 7'd5),
            dr(ids_pkg::OP_INSERT, -8'sd7, 16'h7777, 1, ids_pkg::ST_MISS, 16'h0, 7'd5),
            // read or remove at index equal to size is a miss
            dr(ids_pkg::OP_READ, 8'd5, 16'h0000, 1, ids_pkg::ST_MISS, 16'h0, 7'd5),
            dr(ids_pkg::OP_READ, -8'sd5, 16'h0000, 0, ids_pkg::ST_OK, 16'h0, 7'd0),
            dr(ids_pkg::OP_READ, -8'sd6, 16'h0000, 1, ids_pkg::ST_MISS, 16'h0, 7'd5),
            dr(ids_pkg::OP_REMOVE, -8'sd1, 16'h0000, 0, ids_pkg::ST_OK, 16'h0, 7'd0),
            dr(ids_pkg::OP_REMOVE, 8'd127, 16'h0000, 1, ids_pkg::ST_MISS, 16'h0, 7'd4),
            dr(ids_pkg::OP_REMOVE, 8'h80, 16'h0000, 1, ids_pkg::ST_MISS, 16'h0, 7'd4),
            dr(ids_pkg::OP_FIND, 8'd0, 16'hFFFF, 0, ids_pkg::ST_OK, 16'h0, 7'd0),
            dr(ids_pkg::OP_POP_FRONT, 8'd0, 16'h0000, 0, ids_pkg::ST_OK, 16'h0, 7'd0),
            dr(ids_pkg::OP_POP_BACK, 8'd0, 16'h0000, 0, ids_pkg::ST_OK, 16'h0, 7'd0)
        };

        full_tbl = {
            // Full list: every way in is refused, position checked after fullness
            dr(ids_pkg::OP_PUSH_FRONT, 8'd0, 16'hFFFF, 1, ids_pkg::ST_FULL, 16'h0, 7'd64),
            dr(ids_pkg::OP_PUSH_BACK, 8'd0, 16'hFFFF, 1, ids_pkg::ST_FULL, 16'h0, 7'd64),
            dr(ids_pkg::OP_INSERT, 8'd127, 16'h0001, 1, ids_pkg::ST_FULL, 16'h0, 7'd64),
            dr(ids_pkg::OP_READ, 8'd64, 16'h0000, 1, ids_pkg::ST_MISS, 16'h0, 7'd64),
            dr(ids_pkg::OP_READ, -8'sd64, 16'h0000, 0, ids_pkg::ST_OK, 16'h0, 7'd0)
        };

        // Hold reset, release it on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (opening_tbl[i])
            send_req(opening_tbl[i].op, opening_tbl[i].pos, opening_tbl[i].id,
                     opening_tbl[i].pin, opening_tbl[i].want);
        // fill to the top with random identifiers
        while (id_list_q.size() < LIST_DEPTH)
            send_req(ids_pkg::OP_PUSH_BACK, 8'($urandom), 16'($urandom), 1'b0, '0);
        foreach (full_tbl[i])
            send_req(full_tbl[i].op, full_tbl[i].pos, full_tbl[i].id,
                     full_tbl[i].pin, full_tbl[i].want);

        // Random part: swing the fill level between empty and full
        growing = 1'b0;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin snd_idle_pct = 17; rcv_idle_pct = 56; end
                1: begin snd_idle_pct = 56; rcv_idle_pct = 17; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                n = id_list_q.size();
                if (n == LIST_DEPTH) growing = 1'b0;
                else if (n == 0) growing = 1'b1;
                else if ($urandom_range(47) == 0) growing = !growing;

                // identifiers: half fully random, half from a small set for repeats
                if ($urandom_range(1)) id = 16'($urandom);
                else id = {2'($urandom_range(3)), 14'h15A5};

                r = $urandom_range(99);
                if (r < 10) begin
                    op  = ids_pkg::t_op'($urandom_range(7));
                    pos = 8'($urandom);
                end else begin
                    if (r < 30) begin
                        op = $urandom_range(1) ? ids_pkg::OP_READ : ids_pkg::OP_FIND;
                    end else if (($urandom_range(99) < 75) == growing) begin
                        op = ids_pkg::t_op'($urandom_range(1) ? ids_pkg::OP_INSERT :
                                            $urandom_range(1));
                    end else begin
                        op = ids_pkg::t_op'($urandom_range(1) ? ids_pkg::OP_REMOVE :
                                            $urandom_range(3, 2));
                    end
                    // mostly legal positions, some just outside the legal range
                    if (op == ids_pkg::OP_INSERT) begin
                        if ($urandom_range(99) < 15)
                            pos = $urandom_range(1) ? 8'(n + 1) : 8'(-n - 2);
                        else
                            pos = 8'(int'($urandom_range(2 * n + 1)) - n - 1);
                    end else if (n == 0 || $urandom_range(99) < 15) begin
                        pos = $urandom_range(1) ? 8'(n) : 8'(-n - 1);
                    end else begin
                        pos = 8'(int'($urandom_range(2 * n - 1)) - n);
                    end
                    if (op == ids_pkg::OP_FIND && n > 0 && $urandom_range(99) < 70)
                        id = id_list_q[$urandom_range(n - 1)];
                end
                send_req(op, pos, id, 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding responses before reporting
        while (resp_expect_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("indexed_deque_store verification clean");
        end else begin
            $display("indexed_deque_store verification failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #2000000;
        $display("indexed_deque_store verification failed");
        $finish;
    end

endmodule
